[rtl/core/dhfk_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the DH kinematics chain.
`default_nettype none
package dhfk_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int LEN_W        = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CS_W         = 18;   // rounded sine/cosine, Q2.14 with headroom
    localparam int CX_W         = 34;   // CORDIC x/y, Q2.30 with headroom
    localparam int CZ_W         = 33;   // CORDIC residual angle
    localparam int JM_W         = 32;   // joint rotation entries, Q28
    localparam int TJ_W         = 42;   // joint translation, frac + 14
    localparam int MA_W         = 24;
    localparam int MB_W         = 42;
    localparam int PROD_W       = MA_W + MB_W;
    localparam int ACC_W        = 62;
    localparam logic signed [CX_W-1:0] CORDIC_X0 = CX_W'(652032874);
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [LEN_W-1:0]      joint_offset;
        logic signed [LEN_W-1:0]      link_length;
        logic        [ANGLE_BITS-1:0] link_twist;
        logic        [ANGLE_BITS-1:0] joint_angle;
        logic                         last_joint;
    } t_item;

    typedef struct packed {
        logic                         start;
        logic        [ANGLE_BITS-1:0] angle;
    } t_sc_req;

    typedef struct packed {
        logic                         done;
        logic signed [CS_W-1:0]       cos_v;
        logic signed [CS_W-1:0]       sin_v;
    } t_sc_res;

    typedef enum logic [1:0] {
        TK_JM  = 2'd0,
        TK_POS = 2'd1,
        TK_ROT = 2'd2,
        TK_NONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [2:0] n;
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] k;
    } t_tag;

    function automatic logic signed [CZ_W-1:0] atan_at(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return $signed({1'b0, v});
    endfunction

endpackage
`default_nettype wire

[rtl/core/dhfk_front.sv]
// Input queue: accepts DH rows and holds them until the back end takes them.
`default_nettype none
module dhfk_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  dhfk_pkg::t_item      i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_empty,
    output dhfk_pkg::t_item      o_item
);
    import dhfk_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/core/dhfk_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.14 for a binary angle.
`default_nettype none
module dhfk_cordic (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  dhfk_pkg::t_sc_req    i_req,
    output dhfk_pkg::t_sc_res    o_res
);
    import dhfk_pkg::*;

    logic signed [CX_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [CZ_W-1:0] r_z, n_z;
    logic [STEP_W-1:0]      r_i;
    logic [1:0]             r_q;
    logic                   r_busy, r_fin;
    logic signed [CS_W-1:0] cc, ss;
    logic signed [CX_W-1:0] xs, ys, xr, yr;
    logic signed [CZ_W-1:0] at;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = atan_at(r_i);
        if (!r_z[CZ_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
        xr = r_x + CX_W'(32768);
        yr = r_y + CX_W'(32768);
        cc = xr[CX_W-1:16];
        ss = yr[CX_W-1:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= CORDIC_X0;
            r_y <= '0;
            r_z <= CZ_W'({i_req.angle[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}});
            r_q <= i_req.angle[ANGLE_BITS-1 -: 2];
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_fin      <= 1'b0;
            r_i        <= '0;
            o_res.done <= 1'b0;
        end else begin
            o_res.done <= r_fin;
            r_fin      <= 1'b0;
            if (r_fin) begin
                case (r_q)
                    2'd0: begin o_res.cos_v <= cc;  o_res.sin_v <= ss;  end
                    2'd1: begin o_res.cos_v <= -ss; o_res.sin_v <= cc;  end
                    2'd2: begin o_res.cos_v <= -cc; o_res.sin_v <= -ss; end
                    default: begin o_res.cos_v <= ss; o_res.sin_v <= -cc; end
                endcase
            end
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + STEP_W'(1);
                if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/dhfk_engine.sv]
// Back end: sequences sine/cosine, the joint transform and the pose update on one multiplier.
`default_nettype none
module dhfk_engine (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_empty,
    input  dhfk_pkg::t_item             i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic signed [15:0]          o_rot [9],
    output logic signed [31:0]          o_pos [3]
);
    import dhfk_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CA    = 7'b0000010,
        S_CT    = 7'b0000100,
        S_JM    = 7'b0001000,
        S_POS   = 7'b0010000,
        S_ROT   = 7'b0100000,
        S_WB    = 7'b1000000
    } t_state;

    t_state r_state;
    t_item  r_item;
    t_sc_req sc_req;
    t_sc_res sc_res;

    logic signed [CS_W-1:0]  r_ca, r_sa, r_ct, r_st;
    logic signed [JM_W-1:0]  r_jm [9];
    logic signed [TJ_W-1:0]  r_tj [3];
    logic signed [15:0]      r_rot [9];
    logic signed [15:0]      r_nr [9];
    logic signed [31:0]      r_pos [3];
    logic [2:0]              r_n;
    logic [1:0]              r_r, r_c, r_k;
    t_tag                    r_tag, n_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, sum;
    logic signed [MA_W-1:0]  ma;
    logic signed [MB_W-1:0]  mb;
    logic [3:0]              ri, ti;
    logic signed [ACC_W-1:0] rnd;
    logic signed [33:0]      rv;
    logic signed [34:0]      np;
    logic signed [15:0]      rot_sat;
    logic signed [31:0]      pos_sat;
    logic                    wb_ok;

    dhfk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sc_req),
        .o_res   (sc_res)
    );

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign wb_ok = !r_item.last_joint || !o_valid;

    always_comb begin
        sc_req.start = 1'b0;
        sc_req.angle = r_item.joint_angle;
        if (o_pop) begin
            sc_req.start = 1'b1;
            sc_req.angle = i_item.link_twist;
        end else if (r_state == S_CA && sc_res.done) begin
            sc_req.start = 1'b1;
        end
    end

    // operand select for the issuing step
    always_comb begin
        ri = {2'b0, r_r} * 4'd3 + {2'b0, r_k};
        ti = {2'b0, r_k} * 4'd3 + {2'b0, r_c};
        ma = '0;
        mb = '0;
        n_tag = '0;
        n_tag.n = r_n;
        n_tag.r = r_r;
        n_tag.c = r_c;
        n_tag.k = r_k;
        n_tag.kind = TK_NONE;
        case (r_state)
            S_JM: begin
                n_tag.valid = 1'b1;
                n_tag.kind  = TK_JM;
                case (r_n)
                    3'd0: begin ma = MA_W'(r_ca); mb = MB_W'(r_st); end
                    3'd1: begin ma = MA_W'(r_st); mb = MB_W'(r_sa); end
                    3'd2: begin ma = MA_W'(r_ca); mb = MB_W'(r_ct); end
                    3'd3: begin ma = MA_W'(r_sa); mb = MB_W'(r_ct); end
                    3'd4: begin ma = r_item.link_length; mb = MB_W'(r_ct); end
                    default: begin ma = r_item.link_length; mb = MB_W'(r_st); end
                endcase
            end
            S_POS: begin
                n_tag.valid = 1'b1;
                n_tag.kind  = TK_POS;
                ma = MA_W'(r_rot[ri]);
                mb = r_tj[r_k];
            end
            S_ROT: begin
                n_tag.valid = 1'b1;
                n_tag.kind  = TK_ROT;
                ma = MA_W'(r_rot[ri]);
                mb = MB_W'(r_jm[ti]);
            end
            default: ;
        endcase
    end

    // accumulate and round the product from the previous cycle
    always_comb begin
        sum = (r_tag.k == 2'd0) ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        rnd = sum + ACC_W'(64'sd134217728);
        rv  = rnd[61:28];
        np  = 35'(r_pos[r_tag.r]) + 35'(rv);
        if (rv > 34'sd32767)       rot_sat = 16'sh7fff;
        else if (rv < -34'sd32768) rot_sat = 16'sh8000;
        else                       rot_sat = rv[15:0];
        if (np > 35'sd2147483647)       pos_sat = 32'sh7fffffff;
        else if (np < -35'sd2147483648) pos_sat = 32'sh80000000;
        else                            pos_sat = np[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        r_acc  <= sum;
        if (o_pop) r_item <= i_item;
        if (r_state == S_CA && sc_res.done) begin
            r_ca <= sc_res.cos_v;
            r_sa <= sc_res.sin_v;
        end
        if (r_state == S_CT && sc_res.done) begin
            r_ct    <= sc_res.cos_v;
            r_st    <= sc_res.sin_v;
            r_jm[0] <= JM_W'(sc_res.cos_v) <<< 14;
            r_jm[3] <= JM_W'(sc_res.sin_v) <<< 14;
            r_jm[6] <= '0;
            r_jm[7] <= JM_W'(r_sa) <<< 14;
            r_jm[8] <= JM_W'(r_ca) <<< 14;
            r_tj[2] <= TJ_W'(r_item.joint_offset) <<< 14;
        end
        if (r_tag.valid) begin
            case (r_tag.kind)
                TK_JM: begin
                    case (r_tag.n)
                        3'd0: r_jm[1] <= -r_prod[JM_W-1:0];
                        3'd1: r_jm[2] <= r_prod[JM_W-1:0];
                        3'd2: r_jm[4] <= r_prod[JM_W-1:0];
                        3'd3: r_jm[5] <= -r_prod[JM_W-1:0];
                        3'd4: r_tj[0] <= r_prod[TJ_W-1:0];
                        default: r_tj[1] <= r_prod[TJ_W-1:0];
                    endcase
                end
                TK_ROT: begin
                    if (r_tag.k == 2'd2) begin
                        r_nr[{2'b0, r_tag.r} * 4'd3 + {2'b0, r_tag.c}] <= rot_sat;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_WB && !r_tag.valid && wb_ok && r_item.last_joint) begin
            o_rot <= r_nr;
            o_pos <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tag   <= '0;
            r_n     <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < 9; i++) r_rot[i] <= (i % 4 == 0) ? ONE_Q14 : 16'sd0;
            for (int i = 0; i < 3; i++) r_pos[i] <= '0;
        end else begin
            r_tag <= n_tag;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (r_tag.valid && r_tag.kind == TK_POS && r_tag.k == 2'd2) begin
                r_pos[r_tag.r] <= pos_sat;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) r_state <= S_CA;
                end
                S_CA: begin
                    if (sc_res.done) r_state <= S_CT;
                end
                S_CT: begin
                    if (sc_res.done) begin
                        r_state <= S_JM;
                        r_n     <= '0;
                    end
                end
                S_JM: begin
                    r_n <= r_n + 3'd1;
                    if (r_n == 3'd5) begin
                        r_state <= S_POS;
                        r_r     <= '0;
                        r_k     <= '0;
                    end
                end
                S_POS: begin
                    r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_r <= (r_r == 2'd2) ? 2'd0 : r_r + 2'd1;
                        if (r_r == 2'd2) begin
                            r_state <= S_ROT;
                            r_c     <= '0;
                        end
                    end
                end
                S_ROT: begin
                    r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_c <= (r_c == 2'd2) ? 2'd0 : r_c + 2'd1;
                        if (r_c == 2'd2) begin
                            r_r <= (r_r == 2'd2) ? 2'd0 : r_r + 2'd1;
                            if (r_r == 2'd2) r_state <= S_WB;
                        end
                    end
                end
                S_WB: begin
                    // last rotation product lands on the first WB cycle
                    if (!r_tag.valid && wb_ok) begin
                        r_state <= S_IDLE;
                        if (r_item.last_joint) begin
                            o_valid <= 1'b1;
                            for (int i = 0; i < 9; i++)
                                r_rot[i] <= (i % 4 == 0) ? ONE_Q14 : 16'sd0;
                            for (int i = 0; i < 3; i++) r_pos[i] <= '0;
                        end else begin
                            r_rot <= r_nr;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/dh_forward_kinematics_chain_unit.sv]
// A row popped from the queue goes through two 24-step CORDIC runs (twist, then joint
// angle), 42 products through one shared 24x42 multiplier one per cycle, and write-back.
// The engine pops the next row only after the previous one leaves write-back; a row
// ending a chain waits in write-back while the previous pose sits stalled at the output.
// A two-entry input queue and an output register decouple both channels.
// Reset (synchronous, active low) empties the queue and sets the pose to identity.
`default_nettype none
module dh_forward_kinematics_chain_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire signed [23:0]  i_joint_offset,
    input  wire signed [23:0]  i_link_length,
    input  wire        [15:0]  i_link_twist,
    input  wire        [15:0]  i_joint_angle,
    input  wire                i_last_joint,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [15:0] o_rot_00,
    output logic signed [15:0] o_rot_01,
    output logic signed [15:0] o_rot_02,
    output logic signed [15:0] o_rot_10,
    output logic signed [15:0] o_rot_11,
    output logic signed [15:0] o_rot_12,
    output logic signed [15:0] o_rot_20,
    output logic signed [15:0] o_rot_21,
    output logic signed [15:0] o_rot_22,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z
);
    import dhfk_pkg::*;

    t_item in_item, q_item;
    logic  full, empty, pop;
    logic signed [15:0] rot [9];
    logic signed [31:0] pos [3];

    assign in_item.joint_offset = i_joint_offset;
    assign in_item.link_length  = i_link_length;
    assign in_item.link_twist   = i_link_twist;
    assign in_item.joint_angle  = i_joint_angle;
    assign in_item.last_joint   = i_last_joint;
    assign o_stall = full;

    dhfk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !full),
        .i_item  (in_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (q_item)
    );

    dhfk_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rot   (rot),
        .o_pos   (pos)
    );

    assign o_rot_00 = rot[0];
    assign o_rot_01 = rot[1];
    assign o_rot_02 = rot[2];
    assign o_rot_10 = rot[3];
    assign o_rot_11 = rot[4];
    assign o_rot_12 = rot[5];
    assign o_rot_20 = rot[6];
    assign o_rot_21 = rot[7];
    assign o_rot_22 = rot[8];
    assign o_pos_x  = pos[0];
    assign o_pos_y  = pos[1];
    assign o_pos_z  = pos[2];
endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the DH forward kinematics chain unit.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dhfk_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_ROWS = 1540;

    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [31:0] pos [3];
    } t_pose;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [23:0] i_joint_offset = '0;
    logic signed [23:0] i_link_length = '0;
    logic [15:0] i_link_twist = '0;
    logic [15:0] i_joint_angle = '0;
    logic i_last_joint = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12;
    logic signed [15:0] o_rot_20, o_rot_21, o_rot_22;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;

    dh_forward_kinematics_chain_unit i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // running pose kept alongside the block
    logic signed [15:0] chain_rot [9];
    logic signed [31:0] chain_pos [3];
    t_pose pose_queue [$];
    int    fail_count = 0;
    int    pose_count = 0;
    int    row_count  = 0;
    longint cycle_count = 0;

    const longint ATAN_TURN [24] = '{536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
        logic [31:0] t;
        longint x, y, z, nx, cc, ss;
        t = {ang, 16'h0};
        z = longint'(t[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TURN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TURN[i];
            end
            x = nx;
        end
        cc = (x + 32768) >>> 16;
        ss = (y + 32768) >>> 16;
        case (t[31:30])
            2'd0: begin c = cc; s = ss; end
            2'd1: begin c = -ss; s = cc; end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void reset_chain();
        for (int i = 0; i < 9; i++) chain_rot[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
        for (int i = 0; i < 3; i++) chain_pos[i] = '0;
    endfunction

    // apply one joint row to the pose; queue the pose when the row ends the chain
    function automatic void advance_chain(input logic signed [23:0] d,
            input logic signed [23:0] a, input logic [15:0] tw,
            input logic [15:0] th, input logic last);
        longint ca, sa, ct, st, acc;
        longint jm [9];
        longint tj [3];
        logic signed [15:0] nr [9];
        t_pose p;
        sin_cos(tw, ca, sa);
        sin_cos(th, ct, st);
        jm = '{ct * 16384, -(ca * st), st * sa, st * 16384, ca * ct, -(sa * ct),
               0, sa * 16384, ca * 16384};
        tj = '{longint'(a) * ct, longint'(a) * st, longint'(d) * 16384};
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += longint'(chain_rot[r*3+k]) * tj[k];
            acc = longint'(chain_pos[r]) + ((acc + (64'sd1 <<< 27)) >>> 28);
            chain_pos[r] = 32'(clamp(acc, -64'sd2147483648, 64'sd2147483647));
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += longint'(chain_rot[r*3+k]) * jm[k*3+c];
                nr[r*3+c] = 16'(clamp((acc + (64'sd1 <<< 27)) >>> 28, -32768, 32767));
            end
        chain_rot = nr;
        if (last) begin
            p.rot = chain_rot;
            p.pos = chain_pos;
            pose_queue = {pose_queue, p};
            reset_chain();
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH pose %0d %s: got %0d expected %0d", pose_count, what, got, want);
        fail_count++;
    endtask

    // sender: hold request through stalls
    task automatic send_row(input logic signed [23:0] d, input logic signed [23:0] a,
                            input logic [15:0] tw, input logic [15:0] th, input logic last);
        i_valid        <= 1'b1;
        i_joint_offset <= d;
        i_link_length  <= a;
        i_link_twist   <= tw;
        i_joint_angle  <= th;
        i_last_joint   <= last;
        do @(posedge i_clk); while (o_stall);
        advance_chain(d, a, tw, th, last);
        row_count++;
        @(negedge i_clk);
    endtask

    typedef struct {
        logic signed [23:0] d, a;
        logic [15:0] tw, th;
        logic last;
        bit   known;
        logic signed [15:0] r00, r11, r22;
    } t_row;

    // known expectations: identity joints, and half turns around z
    t_row directed [] = '{
        '{24'sd0, 24'sd0, 16'h0000, 16'h0000, 1'b1, 1, 16'sd16384, 16'sd16384, 16'sd16384},
        '{24'sd0, 24'sd0, 16'h0000, 16'h8000, 1'b1, 1, -16'sd16384, -16'sd16384, 16'sd16384},
        '{24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0, 0},
        '{24'sh7FFFFF, 24'sh7FFFFF, 16'h4000, 16'h4000, 1'b0, 0, 0, 0, 0},
        '{24'sh800000, 24'sh800000, 16'hC000, 16'hC000, 1'b1, 0, 0, 0, 0},
        '{24'sh800000, 24'sh800000, 16'h8000, 16'h0000, 1'b0, 0, 0, 0, 0},
        '{24'sh800000, 24'sh7FFFFF, 16'h2000, 16'hE000, 1'b0, 0, 0, 0, 0},
        '{24'sh7FFFFF, 24'sh800000, 16'h6000, 16'hA000, 1'b1, 0, 0, 0, 0},
        '{24'sh000001, 24'shFFFFFF, 16'h0001, 16'h7FFF, 1'b1, 0, 0, 0, 0},
        '{24'sh555555, 24'shAAAAAA, 16'h5555, 16'hAAAA, 1'b0, 0, 0, 0, 0},
        '{24'shAAAAAA, 24'sh555555, 16'hAAAA, 16'h5555, 1'b1, 0, 0, 0, 0}
    };

    // directed rows, then a saturation run (long chain of max-length straight links), then random rows with gaps
    task automatic drive_stimulus();
        int burst;
        int gap;
        logic last;
        foreach (directed[i])
            send_row(directed[i].d, directed[i].a, directed[i].tw, directed[i].th,
                     directed[i].last);
        for (int i = 0; i < 300; i++)
            send_row(24'sh7FFFFF, 24'sh7FFFFF, 16'h0000, 16'h0000, i == 299);
        for (int i = 0; i < RANDOM_ROWS; i++) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40)) : 0;
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst = int'($urandom_range(1, 12));
            end
            burst--;
            last = ($urandom_range(0, 3) == 0);
            send_row(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom), last);
        end
        send_row(24'sd0, 24'sd0, 16'h0000, 16'h0000, 1'b1);
        i_valid <= 1'b0;
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (cycle_count % 3000 < 1000) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < 40);
    end

    int checked_idx = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_valid && !i_stall) begin
            logic signed [15:0] got_rot [9];
            logic signed [31:0] got_pos [3];
            t_pose want;
            got_rot = '{o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12,
                        o_rot_20, o_rot_21, o_rot_22};
            got_pos = '{o_pos_x, o_pos_y, o_pos_z};
            if (pose_queue.size() == 0) begin
                report_mismatch("unexpected pose", 1, 0);
            end else begin
                want = pose_queue.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got_rot[i] !== want.rot[i])
                        report_mismatch($sformatf("rot_%0d%0d", i / 3, i % 3),
                                        got_rot[i], want.rot[i]);
                for (int i = 0; i < 3; i++)
                    if (got_pos[i] !== want.pos[i])
                        report_mismatch($sformatf("pos[%0d]", i), got_pos[i], want.pos[i]);
                // directed rows with results known in advance
                while (checked_idx < directed.size() && !directed[checked_idx].last)
                    checked_idx++;
                if (checked_idx < directed.size()) begin
                    if (directed[checked_idx].known &&
                        (o_rot_00 !== directed[checked_idx].r00 ||
                         o_rot_11 !== directed[checked_idx].r11 ||
                         o_rot_22 !== directed[checked_idx].r22))
                        report_mismatch("known diagonal", o_rot_00,
                                        directed[checked_idx].r00);
                    checked_idx++;
                end
            end
            pose_count++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        reset_chain();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        drive_stimulus();
        while (pose_queue.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("Drove %0d joint rows and compared %0d end poses", row_count, pose_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
